// ===== hdl/mrf_pkg.sv =====
// Shared types and constants of the Modbus RTU request framer.
`default_nettype none

package mrf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One queue entry: an optional data byte and, on the last request character,
  // the CRC trailer that follows it.
  typedef struct packed {
    logic        has_data;
    logic        is_last;
    logic [7:0]  data_byte;
    logic [15:0] crc;
  } mrf_entry_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI
  } mrf_phase_t;

endpackage

`default_nettype wire

// ===== hdl/mrf_front.sv =====
// Front end: hex pair decoding and CRC-16/Modbus update per data byte.
`default_nettype none

module mrf_front
  import mrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] char_code,
  input  wire logic       last_char,
  output logic            push,
  output mrf_entry_t      entry
);

  logic [15:0] crc_accum;
  logic [15:0] crc_accum_next;
  logic [3:0]  high_nibble;
  logic [3:0]  high_nibble_next;
  logic        second_half;
  logic        second_half_next;
  logic        pair_stopped;
  logic        pair_stopped_next;

  logic        is_hex;
  logic [3:0]  nib;
  logic [7:0]  data_byte;
  logic        has_data;
  logic [15:0] crc_fold;

  always_comb begin
    is_hex = 1'b0;
    nib    = 4'h0;
    if (char_code inside {[8'h30:8'h39]}) begin
      is_hex = 1'b1;
      nib    = 4'(char_code - 8'h30);
    end else if (char_code inside {[8'h41:8'h46]}) begin
      is_hex = 1'b1;
      nib    = 4'(char_code - 8'h37);
    end
  end

  // Fold one byte into the CRC, one bit per step.
  always_comb begin
    crc_fold = crc_accum ^ {8'h00, data_byte};
    for (int i = 0; i < 8; i++) begin
      crc_fold = crc_fold[0] ? ((crc_fold >> 1) ^ CRC_POLY) : (crc_fold >> 1);
    end
  end

  always_comb begin
    has_data          = second_half;
    data_byte         = {4'h0, high_nibble};
    crc_accum_next    = crc_accum;
    high_nibble_next  = high_nibble;
    second_half_next  = second_half;
    pair_stopped_next = pair_stopped;
    if (!second_half) begin
      high_nibble_next  = is_hex ? nib : 4'h0;
      pair_stopped_next = !is_hex;
      second_half_next  = 1'b1;
    end else begin
      if (!pair_stopped && is_hex) begin
        data_byte = {high_nibble, nib};
      end
      crc_accum_next    = crc_fold;
      high_nibble_next  = 4'h0;
      second_half_next  = 1'b0;
      pair_stopped_next = 1'b0;
    end
    // End of request: drop any odd character and start over.
    if (last_char) begin
      crc_accum_next    = CRC_INIT;
      high_nibble_next  = 4'h0;
      second_half_next  = 1'b0;
      pair_stopped_next = 1'b0;
    end
  end

  assign push            = accept && (has_data || last_char);
  assign entry.has_data  = has_data;
  assign entry.is_last   = last_char;
  assign entry.data_byte = data_byte;
  assign entry.crc       = has_data ? crc_fold : crc_accum;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum    <= CRC_INIT;
      high_nibble  <= 4'h0;
      second_half  <= 1'b0;
      pair_stopped <= 1'b0;
    end else if (accept) begin
      crc_accum    <= crc_accum_next;
      high_nibble  <= high_nibble_next;
      second_half  <= second_half_next;
      pair_stopped <= pair_stopped_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mrf_queue.sv =====
// Short register queue between the decoding front end and the byte sequencer.
`default_nettype none

module mrf_queue
  import mrf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire mrf_entry_t push_entry,
  input  wire logic       pop,
  output logic            full,
  output logic            head_valid,
  output mrf_entry_t      head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mrf_entry_t       slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= CntW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== hdl/mrf_back.sv =====
// Back end: sequences data and CRC bytes of each queue entry into the output register.
`default_nettype none

module mrf_back
  import mrf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire mrf_entry_t head,
  output logic            pop,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,
  output logic            m_axis_tuser,
  output logic            m_axis_tlast
);

  mrf_phase_t phase;
  mrf_phase_t phase_next;
  mrf_phase_t eff;
  mrf_phase_t adv;
  logic       load;
  logic       done;
  logic [7:0] byte_sel;
  logic       crc_sel;
  logic       last_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DATA;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    eff      = (phase == PH_DATA && !head.has_data) ? PH_CRC_LO : phase;
    load     = head_valid && (!m_axis_tvalid || m_axis_tready);
    byte_sel = head.data_byte;
    crc_sel  = 1'b0;
    last_sel = 1'b0;
    done     = 1'b1;
    adv      = PH_DATA;
    case (eff)
      PH_DATA: begin
        done = !head.is_last;
        adv  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        byte_sel = head.crc[7:0];
        crc_sel  = 1'b1;
        done     = 1'b0;
        adv      = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        byte_sel = head.crc[15:8];
        crc_sel  = 1'b1;
        last_sel = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
    pop        = load && done;
    phase_next = phase;
    if (load) begin
      phase_next = done ? PH_DATA : adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Hold the payload while the receiver stalls.
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= byte_sel;
      m_axis_tuser <= crc_sel;
      m_axis_tlast <= last_sel;
    end
  end

`ifndef SYNTHESIS
  a_last_is_crc: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("frame end on a non-CRC byte");
  a_mid_entry_head: assert property (@(posedge clk) disable iff (rst)
      (phase != PH_DATA) |-> head_valid)
    else $error("CRC phase without a queued request");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
      (m_axis_tvalid && !m_axis_tready) |-> !pop)
    else $error("entry retired while output stalled");
`endif

endmodule

`default_nettype wire

// ===== hdl/modbus_rtu_request_framer_unit.sv =====
// Top level of the Modbus RTU request framer: front end, queue and byte sequencer.
// Usage:
//   Input stream s_axis carries one ASCII hex character of the request per transfer,
//   with s_axis_tlast on the final character. Two characters make one data byte.
//   Output stream m_axis carries the framed RTU message: each data byte, then the
//   CRC-16/Modbus low and high bytes (tuser high), tlast on the CRC high byte.
//   Throughput: one character per cycle while the queue is not full. A character
//   that completes a byte yields one output byte; the final character adds two CRC
//   bytes, so its entry occupies the output register for each of its bytes in turn.
//   A byte accepted on s_axis is registered in the queue, then in the output register.
//   The queue of DEPTH entries lets characters keep flowing while the output is busy
//   with a CRC trailer; s_axis_tready drops only when the queue is full.
//   Receiver stall: the output byte holds, the queue fills, then input stalls.
//   Reset: queue empty, output invalid, CRC at 0xFFFF, expecting a pair's first char.
`default_nettype none

module modbus_rtu_request_framer_unit
  import mrf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  wire logic       s_axis_tlast,   // last_char
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] frame_byte
  output logic            m_axis_tuser,   // is_crc
  output logic            m_axis_tlast    // last_byte
);

  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       head_valid;
  mrf_entry_t push_entry;
  mrf_entry_t head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mrf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (s_axis_tdata),
    .last_char (s_axis_tlast),
    .push      (push),
    .entry     (push_entry)
  );

  mrf_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  mrf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/tb_modbus_rtu_request_framer_unit.sv =====
// Self-checking testbench of the Modbus RTU request framer: directed table, then random requests.
`default_nettype none

module tb_modbus_rtu_request_framer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_CHARS = 270;
  localparam int CALM_FROM   = 230;
  localparam int CYCLE_LIMIT = 60000;

  typedef struct packed {
    logic [7:0] octet;
    logic       crc_flag;
    logic       end_flag;
  } frame_beat_t;

  // typed rows carry their outcome; the others are left to the predictor
  typedef struct packed {
    logic [7:0]  code;
    logic        fin;
    logic        typed;
    logic        has_data;
    logic [7:0]  data;
    logic [15:0] crc;
  } stim_row_t;

  localparam int N_ROWS = 25;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    '{"5",   1'b1, 1'b1, 1'b0, 8'h00, 16'hFFFF},  // single-character request
    '{"G",   1'b1, 1'b1, 1'b0, 8'h00, 16'hFFFF},  // single non-hex character
    '{"0",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"0",   1'b0, 1'b1, 1'b1, 8'h00, 16'h0000},
    '{"F",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"F",   1'b0, 1'b1, 1'b1, 8'hFF, 16'h0000},
    '{"9",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"A",   1'b0, 1'b1, 1'b1, 8'h9A, 16'h0000},
    '{":",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},  // non-hex first: second is ignored
    '{"5",   1'b0, 1'b1, 1'b1, 8'h00, 16'h0000},
    '{"7",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"@",   1'b0, 1'b1, 1'b1, 8'h07, 16'h0000},  // non-hex second: nibble unshifted
    '{"A",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"/",   1'b0, 1'b1, 1'b1, 8'h0A, 16'h0000},
    '{"F",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"a",   1'b0, 1'b1, 1'b1, 8'h0F, 16'h0000},  // lowercase is not hex
    '{8'hB9, 1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},  // '9' with the top bit set
    '{"3",   1'b0, 1'b1, 1'b1, 8'h00, 16'h0000},
    '{"1",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"2",   1'b1, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{"3",   1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"4",   1'b0, 1'b1, 1'b1, 8'h34, 16'h0000},
    '{"5",   1'b1, 1'b0, 1'b0, 8'h00, 16'h0000},  // odd trailing character
    '{8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 16'h0000},
    '{"Z",   1'b1, 1'b0, 1'b0, 8'h00, 16'h0000}
  };

  localparam string HEX_CHARS = "0123456789ABCDEF";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  modbus_rtu_request_framer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [15:0] crc_now;
  logic [3:0]  nib_hi;
  logic        in_pair;
  logic        pair_void;

  frame_beat_t due_frame_bytes[$];
  frame_beat_t fresh_beats[$];
  int          fails = 0;
  int          chars_sent = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ mrf_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic clear_framer();
    crc_now   = mrf_pkg::CRC_INIT;
    nib_hi    = 4'h0;
    in_pair   = 1'b0;
    pair_void = 1'b0;
  endtask

  // Append the bytes one request character produces to fresh_beats.
  task automatic frame_char(input logic [7:0] code, input logic fin);
    logic [3:0] nib;
    logic [7:0] b;
    logic       ok;
    ok = hex_val(code, nib);
    if (!in_pair) begin
      nib_hi    = ok ? nib : 4'h0;
      pair_void = !ok;
      in_pair   = 1'b1;
    end else begin
      if (pair_void || !ok) b = {4'h0, nib_hi};
      else b = {nib_hi, nib};
      fresh_beats.push_back('{b, 1'b0, 1'b0});
      crc_now   = crc16_fold(crc_now, b);
      in_pair   = 1'b0;
      pair_void = 1'b0;
      nib_hi    = 4'h0;
    end
    if (fin) begin
      fresh_beats.push_back('{crc_now[7:0], 1'b1, 1'b0});
      fresh_beats.push_back('{crc_now[15:8], 1'b1, 1'b1});
      clear_framer();
    end
  endtask

  task automatic send_row(input stim_row_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.code;
    s_axis_tlast  <= r.fin;
    do @(posedge clk); while (!s_axis_tready);
    fresh_beats.delete();
    frame_char(r.code, r.fin);
    if (r.typed) begin
      if (r.has_data) due_frame_bytes.push_back('{r.data, 1'b0, 1'b0});
      if (r.fin) begin
        due_frame_bytes.push_back('{r.crc[7:0], 1'b1, 1'b0});
        due_frame_bytes.push_back('{r.crc[15:8], 1'b1, 1'b1});
      end
    end else begin
      foreach (fresh_beats[i]) due_frame_bytes.push_back(fresh_beats[i]);
    end
    chars_sent++;
    calm = (chars_sent >= CALM_FROM);
  endtask

  task automatic drain_frames();
    while (due_frame_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char(input bit noisy);
    if (noisy || $urandom_range(0, 99) < 12) return 8'($urandom_range(0, 255));
    return HEX_CHARS[$urandom_range(0, 15)];
  endfunction

  // receiver: stall at random, none in the closing stretch
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left    <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_frame_bytes.size() == 0) begin
        $error("unexpected frame byte %h (is_crc %b, last_byte %b)",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fails++;
      end else begin
        frame_beat_t want;
        want = due_frame_bytes.pop_front();
        if (m_axis_tdata !== want.octet) begin
          $error("frame_byte expected %h got %h", want.octet, m_axis_tdata);
          fails++;
        end
        if (m_axis_tuser !== want.crc_flag) begin
          $error("is_crc expected %b got %b", want.crc_flag, m_axis_tuser);
          fails++;
        end
        if (m_axis_tlast !== want.end_flag) begin
          $error("last_byte expected %b got %b", want.end_flag, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modbus_rtu_request_framer_unit verification failed");
      $finish;
    end
  end

  initial begin
    int        len;
    bit        noisy;
    bit        paused;
    stim_row_t r;
    clear_framer();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) send_row(DIR_ROWS[i]);
    s_axis_tvalid <= 1'b0;
    drain_frames();

    paused = 1'b0;
    while (chars_sent < TOTAL_CHARS) begin
      // mostly well-formed hex requests, some of pure noise
      len   = $urandom_range(1, 10);
      noisy = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len; k++) begin
        r          = '0;
        r.code     = pick_char(noisy);
        r.fin      = (k == len - 1);
        send_row(r);
      end
      if (!paused && chars_sent >= TOTAL_CHARS / 2) begin
        // hold input until the output has caught up
        s_axis_tvalid <= 1'b0;
        drain_frames();
        paused = 1'b1;
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    drain_frames();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("modbus_rtu_request_framer_unit verification clean");
    end else begin
      $display("modbus_rtu_request_framer_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/mrf_pkg.sv
hdl/mrf_front.sv
hdl/mrf_queue.sv
hdl/mrf_back.sv
hdl/modbus_rtu_request_framer_unit.sv
tb/tb_modbus_rtu_request_framer_unit.sv
